// ----- rtl/core/matrix_multiply_engine_defines.svh -----
// Assertion helpers for the matrix multiply engine
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

// Check an implication on every clock edge outside reset
`define MME_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");

// Check an implication in the cycle after the antecedent
`define MME_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");

`endif

// ----- rtl/core/mme_pkg.sv -----
package mme_pkg;
   localparam int ElemWidth = 16;
   localparam int SumWidth  = 35;
   localparam int IdxWidth  = 3;
   localparam int DimWidth  = 4;

   typedef enum logic [1:0] {
      REQ_WRITE_A = 2'd0,
      REQ_WRITE_B = 2'd1,
      REQ_COMPUTE = 2'd2,
      REQ_NONE    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_ROWS_M  = 2'd0,
      CSR_COLS_N  = 2'd1,
      CSR_INNER_K = 2'd2,
      CSR_UNUSED  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // Control word handed along the cell chain
   typedef struct packed {
      logic                valid;
      logic                first;
      logic                last;
      logic [IdxWidth-1:0] row;
      logic [IdxWidth-1:0] col;
   } mac_ctrl_type;
endpackage

// ----- rtl/core/mme_ram.sv -----
module mme_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/mme_cell.sv -----
module mme_cell
   import mme_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          stall,
   input  mac_ctrl_type                  ctrl_in,
   input  logic signed [ElemWidth-1:0]   a_in,
   input  logic signed [ElemWidth-1:0]   b_in,
   input  logic signed [SumWidth-1:0]    sum_in,
   output mac_ctrl_type                  ctrl_out,
   output logic signed [ElemWidth-1:0]   a_out,
   output logic signed [ElemWidth-1:0]   b_out,
   output logic signed [SumWidth-1:0]    sum_out
);
   mac_ctrl_type                ctrl_ff;
   logic signed [ElemWidth-1:0] a_ff, b_ff;
   logic signed [SumWidth-1:0]  sum_ff, sum_in_sel;

   // Start a fresh sum on the first term of each dot product
   assign sum_in_sel = ctrl_in.first ? '0 : sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (!stall) begin
         ctrl_ff <= ctrl_in;
      end
   end

   // Hold operands; multiply in the next cell stage
   always_ff @(posedge clock) begin
      if (!stall) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         sum_ff <= sum_in_sel;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign a_out    = a_ff;
   assign b_out    = b_ff;
   assign sum_out  = sum_ff;
endmodule

// ----- rtl/core/mme_acc.sv -----
module mme_acc
   import mme_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        stall,
   input  mac_ctrl_type                ctrl_in,
   input  logic signed [ElemWidth-1:0] a_in,
   input  logic signed [ElemWidth-1:0] b_in,
   input  logic signed [SumWidth-1:0]  sum_in,
   output mac_ctrl_type                ctrl_mid,
   output mac_ctrl_type                ctrl_out,
   output logic signed [SumWidth-1:0]  sum_out
);
   mac_ctrl_type                   ctrl_ff;
   logic signed [2*ElemWidth-1:0]  prod_ff;
   logic signed [SumWidth-1:0]     base_ff;
   logic signed [SumWidth-1:0]     acc_ff, acc_in;
   mac_ctrl_type                   ctrl2_ff;

   // Multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (!stall) begin
         ctrl_ff <= ctrl_in;
      end
   end
   always_ff @(posedge clock) begin
      if (!stall) begin
         prod_ff <= a_in * b_in;
         base_ff <= sum_in;
      end
   end

   // Accumulate stage: chain sum restarts at first, else feeds back
   assign acc_in = (ctrl_ff.first ? base_ff : acc_ff)
                   + SumWidth'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl2_ff <= '0;
      end else if (!stall) begin
         ctrl2_ff <= ctrl_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (!stall && ctrl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign ctrl_mid = ctrl_ff;
   assign ctrl_out = ctrl2_ff;
   assign sum_out  = acc_ff;
endmodule

// ----- rtl/core/matrix_multiply_engine.sv -----
// Load words are taken while the walker is idle and produce no result.
// A compute word walks m*n*k multiply-accumulate steps, one per cycle while the output
// is not stalled, through a RAM read cell, an operand cell and a two-stage
// multiply-accumulate cell; each result element leaves through the output register, and
// the next word is taken once the chain has drained and that register is empty.
// Synchronous active-high reset sets dimensions to 1 and idles the walker; stores undefined.
`include "matrix_multiply_engine_defines.svh"
module matrix_multiply_engine
   import mme_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic [IdxWidth-1:0]   req_row_index,
   input  logic [IdxWidth-1:0]   req_col_index,
   input  logic signed [15:0]    req_elem_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [IdxWidth-1:0]   rsp_out_row,
   output logic [IdxWidth-1:0]   rsp_out_col,
   output logic signed [34:0]    rsp_dot_sum,
   output logic                  rsp_last_result,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [3:0]            csr_data
);
   localparam int Depth = MAX_DIM * MAX_DIM;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int DimW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic [DimWidth-1:0] rows_ff, cols_ff, inner_ff;
   logic [DimWidth-1:0] m_dim, n_dim, k_dim;

   state_type state_ff, state_in;
   logic [DimW-1:0] i_ff, j_ff, t_ff, i_in, j_in, t_in;
   logic req_acc, step, lastkey, pipe_busy;
   logic chain_stall;

   mac_ctrl_type c0_ctrl, c1_ctrl, c2_ctrl, c3_ctrl;
   logic signed [ElemWidth-1:0] a_rd, b_rd, a1, b1;
   logic signed [SumWidth-1:0]  s1, acc_sum;

   logic out_valid_ff;
   logic [IdxWidth-1:0] out_row_ff, out_col_ff;
   logic signed [SumWidth-1:0] out_sum_ff;
   logic out_last_ff;

   function automatic logic [DimWidth-1:0] clamp_dim(input logic [DimWidth-1:0] v);
      if (v == '0) return DimWidth'(1);
      if (v > DimWidth'(MAX_DIM)) return DimWidth'(MAX_DIM);
      return v;
   endfunction

   // Register file
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= DimWidth'(1);
         cols_ff  <= DimWidth'(1);
         inner_ff <= DimWidth'(1);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ROWS_M:  rows_ff  <= csr_data;
            CSR_COLS_N:  cols_ff  <= csr_data;
            CSR_INNER_K: inner_ff <= csr_data;
            default: ;
         endcase
      end
   end
   assign m_dim = clamp_dim(rows_ff);
   assign n_dim = clamp_dim(cols_ff);
   assign k_dim = clamp_dim(inner_ff);

   // Output register stalls the whole chain when full and blocked
   assign chain_stall = out_valid_ff && rsp_stall;
   assign pipe_busy = c0_ctrl.valid || c1_ctrl.valid || c2_ctrl.valid
                      || c3_ctrl.valid;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign step      = (state_ff == ST_RUN) && !chain_stall;
   assign lastkey   = (32'(i_ff) == 32'(m_dim) - 1) && (32'(j_ff) == 32'(n_dim) - 1)
                      && (32'(t_ff) == 32'(k_dim) - 1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_acc && req_kind_type'(req_type) == REQ_COMPUTE)
                      state_in = ST_RUN;
         ST_RUN:   if (step && lastkey) state_in = ST_DRAIN;
         ST_DRAIN: if (!pipe_busy && !out_valid_ff) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Walk counters
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      t_in = t_ff;
      if (req_acc) begin
         i_in = '0;
         j_in = '0;
         t_in = '0;
      end else if (step) begin
         if (32'(t_ff) == 32'(k_dim) - 1) begin
            t_in = '0;
            if (32'(j_ff) == 32'(n_dim) - 1) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end else begin
            t_in = t_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         t_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         t_ff     <= t_in;
      end
   end

   // Element stores
   logic wr_ok;
   logic [AddrW-1:0] wr_addr, a_rd_addr, b_rd_addr;
   assign wr_ok = req_acc && (32'(req_row_index) < MAX_DIM)
                  && (32'(req_col_index) < MAX_DIM);
   assign wr_addr   = AddrW'(32'(req_row_index) * MAX_DIM + 32'(req_col_index));
   assign a_rd_addr = AddrW'(32'(i_ff) * MAX_DIM + 32'(t_ff));
   assign b_rd_addr = AddrW'(32'(t_ff) * MAX_DIM + 32'(j_ff));

   logic [ElemWidth-1:0] a_q, b_q, a_hold_ff, b_hold_ff;
   logic stall_d_ff;
   mme_ram #(.Width(ElemWidth), .Depth(Depth)) u_a_ram (
      .clock(clock), .wr_en(wr_ok && req_kind_type'(req_type) == REQ_WRITE_A),
      .wr_addr(wr_addr), .wr_data(req_elem_value),
      .rd_addr(a_rd_addr), .rd_data(a_q));
   mme_ram #(.Width(ElemWidth), .Depth(Depth)) u_b_ram (
      .clock(clock), .wr_en(wr_ok && req_kind_type'(req_type) == REQ_WRITE_B),
      .wr_addr(wr_addr), .wr_data(req_elem_value),
      .rd_addr(b_rd_addr), .rd_data(b_q));

   // Keep read data steady across a stall (read address moves only on step)
   always_ff @(posedge clock) begin
      if (reset) begin
         stall_d_ff <= 1'b0;
      end else begin
         stall_d_ff <= chain_stall;
      end
      if (!stall_d_ff) begin
         a_hold_ff <= a_q;
         b_hold_ff <= b_q;
      end
   end
   assign a_rd = stall_d_ff ? a_hold_ff : a_q;
   assign b_rd = stall_d_ff ? b_hold_ff : b_q;

   // Read cell: control aligned with the RAM latency
   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ctrl <= '0;
      end else if (!chain_stall) begin
         c0_ctrl.valid <= step;
         c0_ctrl.first <= (t_ff == '0);
         c0_ctrl.last  <= (32'(t_ff) == 32'(k_dim) - 1);
         c0_ctrl.row   <= IdxWidth'(i_ff);
         c0_ctrl.col   <= IdxWidth'(j_ff);
      end
   end

   mme_cell u_cell (
      .clock(clock), .reset(reset), .stall(chain_stall),
      .ctrl_in(c0_ctrl), .a_in(a_rd), .b_in(b_rd), .sum_in('0),
      .ctrl_out(c1_ctrl), .a_out(a1), .b_out(b1), .sum_out(s1));

   mac_ctrl_type c1_q;
   assign c1_q = c1_ctrl;
   mme_acc u_acc (
      .clock(clock), .reset(reset), .stall(chain_stall),
      .ctrl_in(c1_q), .a_in(a1), .b_in(b1), .sum_in(s1),
      .ctrl_mid(c2_ctrl), .ctrl_out(c3_ctrl), .sum_out(acc_sum));

   // Output register
   logic last_elem;
   assign last_elem = (32'(c3_ctrl.row) == 32'(m_dim) - 1)
                      && (32'(c3_ctrl.col) == 32'(n_dim) - 1);
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!chain_stall) begin
         out_valid_ff <= c3_ctrl.valid && c3_ctrl.last;
      end
   end
   always_ff @(posedge clock) begin
      if (!chain_stall) begin
         out_row_ff  <= c3_ctrl.row;
         out_col_ff  <= c3_ctrl.col;
         out_sum_ff  <= acc_sum;
         out_last_ff <= last_elem;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_row     = out_row_ff;
   assign rsp_out_col     = out_col_ff;
   assign rsp_dot_sum     = out_sum_ff;
   assign rsp_last_result = out_last_ff;

   `MME_ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_acc)
   `MME_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `MME_ASSERT_IMPL(a_idle_empty, clock, reset, state_ff == ST_IDLE, !pipe_busy && !rsp_valid)
endmodule
